/* sv/fatdir_pkg.sv */
// ----------------------------------------------------------------------------
// fatdir_pkg
// Shared types and constants for the root directory entry search.
// ----------------------------------------------------------------------------
package fatdir_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned POS_W      = 5;
    localparam int unsigned NAME_LEN   = 11;
    localparam int unsigned NAME_W     = NAME_LEN * BYTE_W;
    localparam int unsigned HEAD_W     = 64;
    localparam int unsigned TAIL_W     = 24;
    localparam int unsigned CLUSTER_W  = 16;
    localparam int unsigned SIZE_ACC_W = 24;
    localparam int unsigned SIZE_W     = 32;
    localparam int unsigned CFG_W      = 64;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [POS_W-1:0] POS_FIRST    = 5'd0;
    localparam logic [POS_W-1:0] POS_ATTR     = 5'd11;
    localparam logic [POS_W-1:0] POS_CLUS_LO  = 5'd26;
    localparam logic [POS_W-1:0] POS_CLUS_HI  = 5'd27;
    localparam logic [POS_W-1:0] POS_SIZE_B0  = 5'd28;
    localparam logic [POS_W-1:0] POS_SIZE_B1  = 5'd29;
    localparam logic [POS_W-1:0] POS_SIZE_B2  = 5'd30;
    localparam logic [POS_W-1:0] POS_LAST     = 5'd31;

    localparam logic [BYTE_W-1:0] MARK_FREE  = 8'hE5;
    localparam logic [BYTE_W-1:0] MARK_END   = 8'h00;
    localparam logic [BYTE_W-1:0] ATTR_LABEL = 8'h08;
    localparam logic [BYTE_W-1:0] ATTR_LONG  = 8'h0F;

    localparam logic [CFG_IDX_W-1:0] REG_NAME_HEAD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NAME_TAIL = 1'b1;

    typedef enum logic [1:0] {
        ST_FOUND      = 2'd0,
        ST_NOT_FOUND  = 2'd1,
        ST_READ_ERROR = 2'd2
    } t_status;

    typedef struct packed {
        logic [POS_W-1:0]      pos;
        logic                  names_equal;
        logic                  entry_skipped;
        logic [CLUSTER_W-1:0]  cluster_acc;
        logic [SIZE_ACC_W-1:0] size_acc;
        logic                  done;
    } t_scan_state;

    typedef struct packed {
        t_status               status;
        logic [CLUSTER_W-1:0]  first_cluster;
        logic [SIZE_W-1:0]     file_size;
    } t_result;

    localparam t_scan_state SCAN_CLEAR = '{
        pos:           POS_FIRST,
        names_equal:   1'b1,
        entry_skipped: 1'b0,
        cluster_acc:   '0,
        size_acc:      '0,
        done:          1'b0
    };

endpackage

/* sv/fat_directory_entry_search.sv */
// ----------------------------------------------------------------------------
// fat_directory_entry_search
// Scans root directory bytes for a short name; reports cluster and size.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                              tuser                  tlast
//  s_axis   in   [7:0] dir_byte                     [0] start_scan         final_byte
//                                                   [1] read_failed
//  m_axis   out  [15:0] first_cluster,              [1:0] search_status    -
//                [47:16] file_size
//  cfg      in   i_cfg_index 0: name head (64b), 1: name tail (24b, low bits)
//
//  One byte per cycle sustained while the output does not stall. Two register
//  stages: input register, then evaluation into the result register, which
//  a result passes through after its byte is accepted. i_rst_n (synchronous)
//  clears both stages, the scan state and the target name. A stalled output
//  holds the input stage only while the result register is full and not taken.
// ----------------------------------------------------------------------------
module fat_directory_entry_search (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [7:0]                          i_s_axis_tdata,  // [7:0] dir_byte
    input  logic [1:0]                          i_s_axis_tuser,  // [0] start_scan, [1] read_failed
    input  logic                                i_s_axis_tlast,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [47:0]                         o_m_axis_tdata,  // [15:0] cluster, [47:16] size
    output logic [1:0]                          o_m_axis_tuser,  // [1:0] search_status
    input  logic                                i_cfg_we,
    input  logic [fatdir_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fatdir_pkg::CFG_W-1:0]        i_cfg_data
);
    import fatdir_pkg::*;

    logic [HEAD_W-1:0] r_name_head;
    logic [TAIL_W-1:0] r_name_tail;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_start;
    logic              r_in_final;
    logic              r_in_failed;

    t_scan_state       r_state;
    t_scan_state       n_state;
    logic              res_valid;
    t_result           res;

    logic              r_out_valid;
    t_result           r_out;

    logic              advance;
    logic              in_take;

    assign advance         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_head <= '0;
            r_name_tail <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_NAME_HEAD: r_name_head <= i_cfg_data;
                REG_NAME_TAIL: r_name_tail <= i_cfg_data[TAIL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte   <= i_s_axis_tdata;
            r_in_start  <= i_s_axis_tuser[0];
            r_in_failed <= i_s_axis_tuser[1];
            r_in_final  <= i_s_axis_tlast;
        end
    end

    fatdir_entry_eval u_eval (
        .i_state       (r_state),
        .i_byte        (r_in_byte),
        .i_start       (r_in_start),
        .i_final       (r_in_final),
        .i_failed      (r_in_failed),
        .i_target_name ({r_name_tail, r_name_head}),
        .o_state       (n_state),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SCAN_CLEAR;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            if (r_in_valid) begin
                r_state <= n_state;
            end
            r_out_valid <= r_in_valid && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.file_size, r_out.first_cluster};
    assign o_m_axis_tuser  = r_out.status;

endmodule

/* sv/fatdir_entry_eval.sv */
// ----------------------------------------------------------------------------
// fatdir_entry_eval
// Per-byte evaluation: next scan state and optional result for one byte.
// ----------------------------------------------------------------------------
module fatdir_entry_eval (
    input  fatdir_pkg::t_scan_state          i_state,
    input  logic [fatdir_pkg::BYTE_W-1:0]    i_byte,
    input  logic                             i_start,
    input  logic                             i_final,
    input  logic                             i_failed,
    input  logic [fatdir_pkg::NAME_W-1:0]    i_target_name,
    output fatdir_pkg::t_scan_state          o_state,
    output logic                             o_res_valid,
    output fatdir_pkg::t_result              o_res
);
    import fatdir_pkg::*;

    t_scan_state       eff;
    logic [3:0]        name_idx;
    logic [BYTE_W-1:0] name_char;
    logic              hit;

    assign eff       = i_start ? SCAN_CLEAR : i_state;
    assign name_idx  = eff.pos[3:0];
    assign name_char = i_target_name[{name_idx, 3'b000} +: BYTE_W];

    always_comb begin
        o_state     = eff;
        o_res_valid = 1'b0;
        o_res       = '{status: ST_NOT_FOUND, first_cluster: '0, file_size: '0};
        hit         = 1'b0;

        if (!eff.done) begin
            if (i_failed) begin
                o_res_valid   = 1'b1;
                o_res.status  = ST_READ_ERROR;
                o_state.done  = 1'b1;
            end else if (eff.pos == POS_FIRST && i_byte == MARK_END) begin
                o_res_valid   = 1'b1;
                o_state.done  = 1'b1;
            end else begin
                if (eff.pos == POS_FIRST && i_byte == MARK_FREE) begin
                    o_state.entry_skipped = 1'b1;
                end
                if (eff.pos < POS_ATTR) begin
                    if (i_byte != name_char) begin
                        o_state.names_equal = 1'b0;
                    end
                end
                case (eff.pos)
                    POS_ATTR: begin
                        if ((i_byte & ATTR_LABEL) != '0 || (i_byte & ATTR_LONG) == ATTR_LONG) begin
                            o_state.entry_skipped = 1'b1;
                        end
                    end
                    POS_CLUS_LO: o_state.cluster_acc[7:0]  = i_byte;
                    POS_CLUS_HI: o_state.cluster_acc[15:8] = i_byte;
                    POS_SIZE_B0: o_state.size_acc[7:0]     = i_byte;
                    POS_SIZE_B1: o_state.size_acc[15:8]    = i_byte;
                    POS_SIZE_B2: o_state.size_acc[23:16]   = i_byte;
                    default: ;
                endcase

                o_state.pos = eff.pos + 5'd1;

                if (eff.pos == POS_LAST) begin
                    hit = eff.names_equal && !eff.entry_skipped;
                    o_state.names_equal   = 1'b1;
                    o_state.entry_skipped = 1'b0;
                    o_state.cluster_acc   = '0;
                    o_state.size_acc      = '0;
                    if (hit) begin
                        o_res_valid         = 1'b1;
                        o_res.status        = ST_FOUND;
                        o_res.first_cluster = eff.cluster_acc;
                        o_res.file_size     = {i_byte, eff.size_acc};
                        o_state.done        = 1'b1;
                    end
                end

                if (!hit && i_final) begin
                    o_res_valid  = 1'b1;
                    o_state.done = 1'b1;
                end
            end
        end
    end

endmodule

/* sv/fatdir_checker.sv */
// ----------------------------------------------------------------------------
// fatdir_checker
// Port-level checks for the directory entry search, bound to the top level.
// ----------------------------------------------------------------------------
module fatdir_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_axis_tvalid,
    input logic                             o_s_axis_tready,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [47:0]                      o_m_axis_tdata,
    input logic [1:0]                       o_m_axis_tuser
);
    import fatdir_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    a_miss_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != ST_FOUND |-> o_m_axis_tdata == '0)
        else $error("non-found result carries data");

    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(i_s_axis_tvalid && o_s_axis_tready, 2))
        else $error("result without accepted byte");

endmodule

bind fat_directory_entry_search fatdir_checker u_fatdir_checker (.*);

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the root directory name search against a cycle-free predictor of
// the scan. Directory bytes go in as stream transactions with random bursts
// and gaps; results are taken with a stalling receiver and compared field by
// field in arrival order. Covers reset-state scans, read errors, end markers,
// skipped entries, matches on the final byte and several target names.
// ----------------------------------------------------------------------------
module tb;
    import fatdir_pkg::*;

    localparam int RANDOM_ITEMS       = 440;
    localparam int SETTLE_CYCLES      = 8;
    localparam int RX_HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT     = 3000;
    localparam int NAMES_EVERY        = 4;

    typedef enum int {
        ENT_MATCH,
        ENT_OTHER_NAME,
        ENT_FREE,
        ENT_LABEL,
        ENT_LONG_NAME,
        ENT_END
    } t_entry_kind;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [7:0]           i_s_axis_tdata = '0;
    logic [1:0]           i_s_axis_tuser = '0;
    logic                 i_s_axis_tlast = 1'b0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [47:0]          o_m_axis_tdata;
    logic [1:0]           o_m_axis_tuser;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    fat_directory_entry_search DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // scan state mirror
    logic [HEAD_W-1:0]     target_head   = '0;
    logic [TAIL_W-1:0]     target_tail   = '0;
    logic [POS_W-1:0]      scan_pos      = POS_FIRST;
    logic                  name_match    = 1'b1;
    logic                  entry_skip    = 1'b0;
    logic [CLUSTER_W-1:0]  cluster_bytes = '0;
    logic [SIZE_ACC_W-1:0] size_bytes    = '0;
    logic                  scan_done     = 1'b0;

    t_result     search_outcomes[$];
    logic [7:0]  dir_stream[$];

    int n_errors = 0;
    int n_used = 0;
    int n_ignored = 0;
    int n_results = 0;
    int n_found = 0;
    int n_not_found = 0;
    int n_read_err = 0;
    int n_cfg_writes = 0;
    int burst_left = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int rx_cycle = 0;
    int stall_cycles = 0;

    task automatic record_outcome(input t_status st, input logic [CLUSTER_W-1:0] cl,
                                  input logic [SIZE_W-1:0] sz);
        t_result r;
        r.status = st;
        r.first_cluster = cl;
        r.file_size = sz;
        search_outcomes.push_back(r);
        scan_done = 1'b1;
        n_results++;
        case (st)
            ST_FOUND:     n_found++;
            ST_NOT_FOUND: n_not_found++;
            default:      n_read_err++;
        endcase
    endtask

    task automatic clear_entry_state();
        name_match = 1'b1;
        entry_skip = 1'b0;
        cluster_bytes = '0;
        size_bytes = '0;
    endtask

    // advance the scan by one accepted directory byte
    task automatic dir_scan_step(input logic [7:0] b, input logic st, input logic fin,
                                 input logic fail);
        logic [POS_W-1:0]      p;
        logic [NAME_W-1:0]     tgt;
        logic                  hit;
        logic [CLUSTER_W-1:0]  cl;
        logic [SIZE_W-1:0]     sz;
        int                    k;
        if (st) begin
            scan_pos = POS_FIRST;
            clear_entry_state();
            scan_done = 1'b0;
        end
        if (scan_done) begin
            n_ignored++;
            return;
        end
        n_used++;
        if (fail) begin
            record_outcome(ST_READ_ERROR, '0, '0);
            return;
        end
        p = scan_pos;
        k = p;
        tgt = {target_tail, target_head};
        if (p == POS_FIRST) begin
            if (b == MARK_END) begin
                record_outcome(ST_NOT_FOUND, '0, '0);
                return;
            end
            if (b == MARK_FREE) entry_skip = 1'b1;
        end
        if (k < NAME_LEN) begin
            if (b != tgt[8*k +: 8]) name_match = 1'b0;
        end else if (p == POS_ATTR) begin
            if ((b & ATTR_LABEL) != '0 || (b & ATTR_LONG) == ATTR_LONG) entry_skip = 1'b1;
        end else begin
            case (p)
                POS_CLUS_LO: cluster_bytes[7:0]  = b;
                POS_CLUS_HI: cluster_bytes[15:8] = b;
                POS_SIZE_B0: size_bytes[7:0]     = b;
                POS_SIZE_B1: size_bytes[15:8]    = b;
                POS_SIZE_B2: size_bytes[23:16]   = b;
                default: ;
            endcase
        end
        scan_pos = p + 1'b1;
        if (p == POS_LAST) begin
            hit = name_match && !entry_skip;
            cl = cluster_bytes;
            sz = {b, size_bytes};
            clear_entry_state();
            if (hit) begin
                record_outcome(ST_FOUND, cl, sz);
                return;
            end
        end
        if (fin) record_outcome(ST_NOT_FOUND, '0, '0);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic st, input logic fin,
                             input logic fail);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tuser  <= {fail, st};
        i_s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!o_s_axis_tready);
        dir_scan_step(b, st, fin, fail);
    endtask

    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (search_outcomes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // upper data bits above the tail width sometimes carry junk on purpose
    task automatic load_name(input logic [HEAD_W-1:0] head, input logic [TAIL_W-1:0] tail);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_NAME_HEAD;
        i_cfg_data  <= head;
        @(posedge i_clk);
        i_cfg_index <= REG_NAME_TAIL;
        i_cfg_data  <= {40'($urandom_range(0, 1) ? {$urandom, $urandom} : 0), tail};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        target_head = head;
        target_tail = tail;
        n_cfg_writes += 2;
    endtask

    function automatic logic [7:0] name_char_rand();
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(8'h30, 8'h5A));
    endfunction

    function automatic t_entry_kind pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return ENT_MATCH;
        if (r < 55) return ENT_OTHER_NAME;
        if (r < 65) return ENT_FREE;
        if (r < 75) return ENT_LABEL;
        if (r < 85) return ENT_LONG_NAME;
        return ENT_END;
    endfunction

    task automatic build_entry(input t_entry_kind kind);
        logic [7:0]        ent[32];
        logic [NAME_W-1:0] tgt;
        int                k;
        tgt = {target_tail, target_head};
        for (k = 0; k < 32; k++) ent[k] = 8'($urandom_range(0, 255));
        for (k = 0; k < NAME_LEN; k++) ent[k] = tgt[8*k +: 8];
        ent[POS_ATTR] = ent[POS_ATTR] & ~ATTR_LABEL;
        case (kind)
            ENT_OTHER_NAME: begin
                k = $urandom_range(0, NAME_LEN - 1);
                ent[k] = ent[k] ^ 8'($urandom_range(1, 255));
            end
            ENT_FREE:      ent[POS_FIRST] = MARK_FREE;
            ENT_LABEL:     ent[POS_ATTR] = ent[POS_ATTR] | ATTR_LABEL;
            ENT_LONG_NAME: ent[POS_ATTR] = ATTR_LONG | (ent[POS_ATTR] & 8'hF0);
            ENT_END:       ent[POS_FIRST] = MARK_END;
            default: ;
        endcase
        if ($urandom_range(0, 7) == 0) begin
            for (k = POS_CLUS_LO; k <= POS_LAST; k++)
                ent[k] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        for (k = 0; k < 32; k++) dir_stream.push_back(ent[k]);
    endtask

    // well-formed run of entries, sometimes cut short, failed or left open
    task automatic run_search();
        int   n_entries;
        int   last;
        int   fail_at;
        int   trail;
        int   i;
        logic with_final;
        dir_stream.delete();
        n_entries = $urandom_range(1, 4);
        for (i = 0; i < n_entries; i++) build_entry(pick_kind());
        last = dir_stream.size() - 1;
        if ($urandom_range(0, 3) == 0) last = $urandom_range(0, last);
        with_final = ($urandom_range(0, 9) != 0);
        fail_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, last) : -1;
        trail = $urandom_range(0, 3);
        for (i = 0; i <= last; i++) begin
            send_byte(dir_stream[i], i == 0, with_final && i == last, i == fail_at);
            if (scan_done) begin
                if (trail == 0) break;
                trail--;
            end
        end
    endtask

    task automatic run_noise();
        int n;
        n = $urandom_range(1, 20);
        repeat (n) begin
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                      $urandom_range(0, 7) == 0, $urandom_range(0, 15) == 0);
        end
    endtask

    // reset state: scan runs without a start flag, target name is zero
    task automatic test_after_reset();
        send_byte(8'h41, 1'b0, 1'b0, 1'b0);
        send_byte(8'h42, 1'b0, 1'b0, 1'b0);
        send_byte(8'h43, 1'b0, 1'b1, 1'b0);
        send_byte(8'h44, 1'b0, 1'b1, 1'b0);
        wait_idle();
    endtask

    task automatic test_read_error();
        send_byte(8'hFF, 1'b1, 1'b0, 1'b1);
        send_byte(8'h00, 1'b0, 1'b0, 1'b1);
        send_byte(8'h20, 1'b1, 1'b1, 1'b1);
        wait_idle();
    endtask

    task automatic test_end_marker();
        send_byte(MARK_END, 1'b1, 1'b0, 1'b0);
        send_byte(MARK_FREE, 1'b1, 1'b0, 1'b0);
        send_byte(MARK_END, 1'b0, 1'b1, 1'b0);
        wait_idle();
    endtask

    task automatic test_match_on_final_byte();
        int k;
        load_name('1, '1);
        for (k = 0; k < 32; k++) begin
            if (k < NAME_LEN || k >= POS_CLUS_LO)
                send_byte(8'hFF, k == 0, k == POS_LAST, 1'b0);
            else if (k == POS_ATTR)
                send_byte(8'h00, 1'b0, 1'b0, 1'b0);
            else
                send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
        end
        wait_idle();
    endtask

    // receiver holds off while short searches keep coming
    task automatic test_output_backpressure();
        int i;
        hold_requests++;
        for (i = 0; i < 16; i++) send_byte(MARK_END, 1'b1, 1'b0, i[0]);
        wait_idle();
    endtask

    task automatic test_random_searches();
        int first_sent;
        int searches;
        int k;
        logic [NAME_W-1:0] tgt;
        first_sent = n_used + n_ignored;
        searches = 0;
        while (n_used + n_ignored - first_sent < RANDOM_ITEMS) begin
            if (searches % NAMES_EVERY == 0) begin
                wait_idle();
                case (searches / NAMES_EVERY)
                    0: tgt = '0;
                    1: tgt = '1;
                    default: for (k = 0; k < NAME_LEN; k++) tgt[8*k +: 8] = name_char_rand();
                endcase
                load_name(tgt[HEAD_W-1:0], tgt[NAME_W-1:HEAD_W]);
            end
            if ($urandom_range(0, 9) == 0) run_noise();
            else run_search();
            searches++;
        end
    endtask

    always @(posedge i_clk) begin
        rx_cycle++;
        if (hold_left != 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = RX_HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else begin
            case ((rx_cycle / 113) % 4)
                0: i_m_axis_tready <= 1'b1;
                1: i_m_axis_tready <= 1'($urandom_range(0, 1));
                2: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: i_m_axis_tready <= (rx_cycle % 7 != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (search_outcomes.size() == 0) begin
                $error("unexpected result transaction: status %0d cluster %h size %h",
                       o_m_axis_tuser, o_m_axis_tdata[15:0], o_m_axis_tdata[47:16]);
                n_errors++;
            end else begin
                want = search_outcomes.pop_front();
                if (o_m_axis_tuser !== want.status) begin
                    $error("search_status: expected %0d, got %0d", want.status, o_m_axis_tuser);
                    n_errors++;
                end
                if (o_m_axis_tdata[15:0] !== want.first_cluster) begin
                    $error("first_cluster: expected %h, got %h",
                           want.first_cluster, o_m_axis_tdata[15:0]);
                    n_errors++;
                end
                if (o_m_axis_tdata[47:16] !== want.file_size) begin
                    $error("file_size: expected %h, got %h",
                           want.file_size, o_m_axis_tdata[47:16]);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
            || (o_m_axis_tvalid && i_m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_after_reset();
        test_read_error();
        test_end_marker();
        test_match_on_final_byte();
        test_output_backpressure();
        test_random_searches();
        wait_idle();
        $display("Scanned %0d directory bytes (%0d more ignored after a finished search).",
                 n_used, n_ignored);
        $display("Checked %0d results: %0d found, %0d not found, %0d read errors; %0d reg writes.",
                 n_results, n_found, n_not_found, n_read_err, n_cfg_writes);
        if (n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
sv/fatdir_pkg.sv
sv/fatdir_entry_eval.sv
sv/fat_directory_entry_search.sv
sv/fatdir_checker.sv
bench/tb.sv
